// ===== hdl/string_literal_escaper_unit_macros.svh =====
// assertion macros for the string literal escaper
`ifndef STRING_LITERAL_ESCAPER_UNIT_MACROS_SVH
`define STRING_LITERAL_ESCAPER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds in the same cycle as the trigger
`define SLE_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("assertion failed");
// condition holds in the cycle after the trigger
`define SLE_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("assertion failed");
`else
`define SLE_ASSERT_SAME(label, clk, rstn, trig, cond)
`define SLE_ASSERT_NEXT(label, clk, rstn, trig, cond)
`endif

`endif

// ===== hdl/sle_pkg.sv =====
`timescale 1ns / 1ps
package sle_pkg;

    // byte store size and derived widths
    localparam int MAX_BYTES = 4096;
    localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // beat kind carried on the input tuser
    typedef enum logic [0:0] {
        CMD_APPEND = 1'b0,
        CMD_EMIT   = 1'b1
    } sle_cmd_t;

    // one emit run: prefix, opening quotes, escaped body, closing quotes
    typedef struct packed {
        logic            pre_en;
        logic [7:0]      pre;
        logic [1:0]      open_n;
        logic [7:0]      quote;
        logic [2:0]      body_n;
        logic [3:0][7:0] body;
        logic [1:0]      close_n;
    } sle_desc_t;

endpackage

// ===== hdl/sle_front.sv =====
`timescale 1ns / 1ps
module sle_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_cmd,
    input  logic [7:0]        in_data_byte,
    input  logic [7:0]        in_prefix_char,
    input  logic              in_triple_mode,
    input  logic              in_is_unicode,
    output logic              push_valid,
    input  logic              push_ready,
    output sle_pkg::sle_desc_t push_data
);
    import sle_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    typedef enum logic [1:0] {
        FS_ACCEPT = 2'b01,
        FS_LOOKUP = 2'b10
    } fs_state_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'b0, v};
        end
        return 8'h57 + {4'b0, v};
    endfunction

    fs_state_t        state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             dq_reg, dq_next;
    logic             fixed_reg, fixed_next;
    logic [7:0]       pre_reg;
    logic             triple_reg, uni_reg, empty_reg, first_reg, last_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [MAX_BYTES];

    logic accept, do_append, do_emit;
    logic [7:0]       b;
    logic [2:0]       body_n;
    logic [3:0][7:0]  body;
    logic [1:0]       quote_n;

    assign in_ready  = (state_reg == FS_ACCEPT);
    assign accept    = in_valid && in_ready;
    assign do_append = accept && (in_cmd == CMD_APPEND) && (count_reg < CNT_W'(MAX_BYTES));
    assign do_emit   = accept && (in_cmd == CMD_EMIT)
                       && ((count_reg == '0) || (ptr_reg < count_reg));

    // byte store: one write port for appends, one registered read for emits
    always_ff @(posedge aclk) begin
        if (do_append) begin
            mem[count_reg[ADDR_W-1:0]] <= in_data_byte;
        end
        if (do_emit) begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
        end
    end

    // control: counts, quote choice and lookup state
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        dq_next    = dq_reg;
        fixed_next = fixed_reg;
        unique case (state_reg)
            FS_ACCEPT: begin
                if (do_append) begin
                    count_next = count_reg + CNT_W'(1);
                    if (!fixed_reg) begin
                        if (in_data_byte == CH_SQUOTE) begin
                            dq_next = 1'b1;
                        end else if (in_data_byte == CH_DQUOTE) begin
                            dq_next    = 1'b0;
                            fixed_next = 1'b1;
                        end
                    end
                end
                if (do_emit) begin
                    state_next = FS_LOOKUP;
                    if (count_reg != '0) begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end
            end
            FS_LOOKUP: begin
                if (push_ready) begin
                    state_next = FS_ACCEPT;
                end
            end
            default: state_next = FS_ACCEPT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_ACCEPT;
            count_reg <= '0;
            ptr_reg   <= '0;
            dq_reg    <= 1'b0;
            fixed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            dq_reg    <= dq_next;
            fixed_reg <= fixed_next;
        end
    end

    // emit beat details held for the lookup state
    always_ff @(posedge aclk) begin
        if (do_emit) begin
            pre_reg    <= in_prefix_char;
            triple_reg <= in_triple_mode;
            uni_reg    <= in_is_unicode;
            empty_reg  <= (count_reg == '0);
            first_reg  <= (ptr_reg == '0);
            last_reg   <= ((ptr_reg + CNT_W'(1)) == count_reg);
        end
    end

    // escape classification of the stored byte
    always_comb begin
        b      = rd_data_reg;
        body   = '0;
        body_n = 3'd1;
        body[0] = b;
        if ((b < CH_SPACE) || (b == CH_DEL) || ((b >= CH_HIGH) && !uni_reg)) begin
            if (b == CH_CR) begin
                body[0] = CH_BSLASH;
                body[1] = CH_R;
                body_n  = 3'd2;
            end else if (b == CH_LF) begin
                if (!triple_reg) begin
                    body[0] = CH_BSLASH;
                    body[1] = CH_N;
                    body_n  = 3'd2;
                end
            end else if (b == CH_TAB) begin
                body[0] = CH_BSLASH;
                body[1] = CH_T;
                body_n  = 3'd2;
            end else begin
                body[0] = CH_BSLASH;
                body[1] = CH_X;
                if (b >= 8'h10) begin
                    body[2] = hex_digit(b[7:4]);
                    body[3] = hex_digit(b[3:0]);
                    body_n  = 3'd4;
                end else begin
                    body[2] = hex_digit(b[3:0]);
                    body_n  = 3'd3;
                end
            end
        end else if ((!dq_reg && (b == CH_SQUOTE)) || (dq_reg && (b == CH_DQUOTE))) begin
            body[0] = CH_BSLASH;
            body[1] = b;
            body_n  = 3'd2;
        end
    end

    // descriptor for the back end
    always_comb begin
        quote_n    = triple_reg ? 2'd3 : 2'd1;
        push_valid = (state_reg == FS_LOOKUP);
        push_data.pre_en = (pre_reg != 8'h00);
        push_data.pre    = pre_reg;
        if (empty_reg) begin
            push_data.open_n  = 2'd1;
            push_data.quote   = CH_SQUOTE;
            push_data.body_n  = 3'd0;
            push_data.body    = '0;
            push_data.close_n = 2'd1;
        end else begin
            push_data.pre_en  = first_reg && (pre_reg != 8'h00);
            push_data.open_n  = first_reg ? quote_n : 2'd0;
            push_data.quote   = dq_reg ? CH_DQUOTE : CH_SQUOTE;
            push_data.body_n  = body_n;
            push_data.body    = body;
            push_data.close_n = last_reg ? quote_n : 2'd0;
        end
    end

endmodule

// ===== hdl/sle_queue.sv =====
`timescale 1ns / 1ps
module sle_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  sle_pkg::sle_desc_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output sle_pkg::sle_desc_t pop_data
);
    import sle_pkg::*;

    sle_desc_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/sle_back.sv =====
`timescale 1ns / 1ps
module sle_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  sle_pkg::sle_desc_t pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_char,
    output logic               m_last,
    output logic               m_done
);
    import sle_pkg::*;

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_RUN  = 2'b10
    } bs_state_t;

    bs_state_t  state_reg, state_next;
    sle_desc_t  desc_reg;
    logic [3:0] pos_reg, pos_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_char_reg, m_char_next;
    logic       m_last_reg, m_last_next;
    logic       m_done_reg, m_done_next;

    logic       out_free;
    logic [3:0] pre_n, open_end, body_end, total, body_off;
    logic [7:0] cur_char;
    logic       cur_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = (state_reg == BS_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_char    = m_char_reg;
    assign m_last    = m_last_reg;
    assign m_done    = m_done_reg;

    // character at the current run position
    always_comb begin
        pre_n    = {3'b0, desc_reg.pre_en};
        open_end = pre_n + {2'b0, desc_reg.open_n};
        body_end = open_end + {1'b0, desc_reg.body_n};
        total    = body_end + {2'b0, desc_reg.close_n};
        body_off = pos_reg - open_end;
        if (pos_reg < pre_n) begin
            cur_char = desc_reg.pre;
        end else if (pos_reg < open_end) begin
            cur_char = desc_reg.quote;
        end else if (pos_reg < body_end) begin
            cur_char = desc_reg.body[body_off[1:0]];
        end else begin
            cur_char = desc_reg.quote;
        end
        cur_last = (pos_reg == (total - 4'd1));
    end

    // run sequencer and output register
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;
        unique case (state_reg)
            BS_IDLE: begin
                if (pop_valid) begin
                    state_next = BS_RUN;
                    pos_next   = '0;
                end
            end
            BS_RUN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = cur_char;
                    m_last_next  = cur_last;
                    m_done_next  = cur_last && (desc_reg.close_n != 2'd0);
                    if (cur_last) begin
                        state_next = BS_IDLE;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BS_IDLE;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
        if (pop_valid && pop_ready) begin
            desc_reg <= pop_data;
        end
    end

endmodule

// ===== hdl/string_literal_escaper_unit.sv =====
`timescale 1ns / 1ps
// Quoted literal builder: append beats (tuser = 0) load bytes into a 4096-byte
// store; emit beats (tuser = 1) each produce the escaped form of the next
// stored byte as a run of 1 to 11 output beats, with tlast on the last beat of
// the run and tuser on the closing quote of the whole literal. The front takes
// no new beat after an emit until the descriptor built from the registered
// store read is pushed; the back puts out one character per cycle while the
// output is not stalled, with an idle step to load each run. A two-entry run
// queue lets the front keep loading bytes while the output side is stalled.
// No clearing pass is needed after reset.
module string_literal_escaper_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [15:8] prefix_char, [16] triple_mode, [17] is_unicode
    input  logic [23:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_char
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] string_done
    output logic [0:0]  m_axis_tuser
);
    import sle_pkg::*;

    `include "string_literal_escaper_unit_macros.svh"

    logic      q_push_valid, q_push_ready;
    sle_desc_t q_push_data;
    logic      q_pop_valid, q_pop_ready;
    sle_desc_t q_pop_data;
    logic      out_done;

    // front: byte store and escape classification
    sle_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_cmd         (s_axis_tuser[0]),
        .in_data_byte   (s_axis_tdata[7:0]),
        .in_prefix_char (s_axis_tdata[15:8]),
        .in_triple_mode (s_axis_tdata[16]),
        .in_is_unicode  (s_axis_tdata[17]),
        .push_valid     (q_push_valid),
        .push_ready     (q_push_ready),
        .push_data      (q_push_data)
    );

    // run queue
    sle_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // back: character sequencer
    sle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_char    (m_axis_tdata),
        .m_last    (m_axis_tlast),
        .m_done    (out_done)
    );

    assign m_axis_tuser[0] = out_done;

    // checks
    `SLE_ASSERT_SAME(a_push_only_in_lookup, aclk, aresetn, q_push_valid, !s_axis_tready)
    `SLE_ASSERT_NEXT(a_out_held, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SLE_ASSERT_SAME(a_done_ends_run, aclk, aresetn, m_axis_tvalid && out_done, m_axis_tlast)

endmodule
